/* hdl/tce_pkg.sv */
// Shared types, codes and constants of the toy CPU execute unit.
package tce_pkg;

  // Storage and field sizes
  localparam int unsigned MEM_WORDS = 4096;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
  localparam int unsigned DISP_BITS = 12;

  localparam logic [31:0] TERM_ADDR = 32'hFFFF_FF04;
  localparam logic [3:0]  REG_ZERO  = 4'd0;
  localparam logic [3:0]  REG_SP    = 4'd14;
  localparam logic [3:0]  REG_PC    = 4'd15;

  // Operation codes
  localparam logic [3:0] OP_HALT  = 4'd0;
  localparam logic [3:0] OP_TRAP  = 4'd1;
  localparam logic [3:0] OP_CALL  = 4'd2;
  localparam logic [3:0] OP_JUMP  = 4'd3;
  localparam logic [3:0] OP_SWAP  = 4'd4;
  localparam logic [3:0] OP_ARITH = 4'd5;
  localparam logic [3:0] OP_LOGIC = 4'd6;
  localparam logic [3:0] OP_SHIFT = 4'd7;
  localparam logic [3:0] OP_STORE = 4'd8;
  localparam logic [3:0] OP_LOAD  = 4'd9;

  // Mode codes per operation
  localparam logic [3:0] CALL_DIR = 4'd0;
  localparam logic [3:0] CALL_IND = 4'd1;
  localparam int unsigned JMP_IND_BIT = 3;
  localparam logic [2:0] BR_ALW = 3'd0;
  localparam logic [2:0] BR_EQ  = 3'd1;
  localparam logic [2:0] BR_NE  = 3'd2;
  localparam logic [2:0] BR_GT  = 3'd3;
  localparam logic [3:0] M_ADD = 4'd0;
  localparam logic [3:0] M_SUB = 4'd1;
  localparam logic [3:0] M_MUL = 4'd2;
  localparam logic [3:0] M_DIV = 4'd3;
  localparam logic [3:0] M_NOT = 4'd0;
  localparam logic [3:0] M_AND = 4'd1;
  localparam logic [3:0] M_OR  = 4'd2;
  localparam logic [3:0] M_XOR = 4'd3;
  localparam logic [3:0] M_SHL = 4'd0;
  localparam logic [3:0] M_SHR = 4'd1;
  localparam logic [3:0] ST_DIR = 4'd0;
  localparam logic [3:0] ST_CSR = 4'd1;
  localparam logic [3:0] ST_IND = 4'd2;
  localparam logic [3:0] LD_CSR   = 4'd0;
  localparam logic [3:0] LD_ADDI  = 4'd1;
  localparam logic [3:0] LD_MEM   = 4'd2;
  localparam logic [3:0] LD_POST  = 4'd3;
  localparam logic [3:0] LD_WCSR  = 4'd4;
  localparam logic [3:0] LD_ORCSR = 4'd5;
  localparam logic [3:0] LD_MCSR  = 4'd6;
  localparam logic [3:0] LD_MPOST = 4'd7;

  // Control register indexes and cause values
  localparam logic [3:0]  CSR_STATUS  = 4'd0;
  localparam logic [3:0]  CSR_HANDLER = 4'd1;
  localparam logic [3:0]  CSR_CAUSE   = 4'd2;
  localparam logic [31:0] CAUSE_KEY   = 32'd3;
  localparam logic [31:0] CAUSE_TRAP  = 32'd4;

  typedef enum logic [3:0] {
    ALU_ADD = 4'd0,
    ALU_SUB = 4'd1,
    ALU_MUL = 4'd2,
    ALU_AND = 4'd3,
    ALU_OR  = 4'd4,
    ALU_XOR = 4'd5,
    ALU_NOT = 4'd6,
    ALU_SHL = 4'd7,
    ALU_SHR = 4'd8,
    ALU_EQ  = 4'd9,
    ALU_NE  = 4'd10,
    ALU_GT  = 4'd11
  } alu_op_e;

  typedef struct packed {
    logic [3:0]                  req_type;
    logic [3:0]                  op_mode;
    logic [3:0]                  reg_a;
    logic [3:0]                  reg_b;
    logic [3:0]                  reg_c;
    logic signed [DISP_BITS-1:0] displacement;
    logic                        key_valid;
    logic [7:0]                  key_char;
  } req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic        invalid_op;
    logic        interrupt_taken;
  } res_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

/* hdl/tce_alu.sv */
// Shared arithmetic, logic, shift and compare unit.
module tce_alu import tce_pkg::*; (
  input  alu_op_e     op_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  output logic [31:0] r_o,
  output logic        cond_o
);

  always_comb begin
    r_o    = '0;
    cond_o = 1'b0;
    case (op_i)
      ALU_ADD: r_o = x_i + y_i;
      ALU_SUB: r_o = x_i - y_i;
      ALU_MUL: r_o = x_i * y_i;
      ALU_AND: r_o = x_i & y_i;
      ALU_OR:  r_o = x_i | y_i;
      ALU_XOR: r_o = x_i ^ y_i;
      ALU_NOT: r_o = ~x_i;
      // shift amounts of 32 or more clear the word
      ALU_SHL: r_o = (|y_i[31:5]) ? '0 : (x_i << y_i[4:0]);
      ALU_SHR: r_o = (|y_i[31:5]) ? '0 : (x_i >> y_i[4:0]);
      ALU_EQ:  cond_o = (x_i == y_i);
      ALU_NE:  cond_o = (x_i != y_i);
      ALU_GT:  cond_o = ($signed(x_i) > $signed(y_i));
      default: r_o = '0;
    endcase
  end

endmodule

/* hdl/tce_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module tce_div import tce_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [5:0]  cnt_q;
  logic        done_q;
  logic [31:0] rem_q, quo_q, dvs_q;
  logic [32:0] trial;

  // shifted partial remainder; a zero divisor always fits, giving all ones
  assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= 6'd32;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[30:0], quo_q[31]};
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* hdl/toy_cpu_execute_unit_top.sv */
// Execute unit top level: sequencer, register file, control registers, data memory.
// Sequence from accept to result beat: each step is one pass through the shared ALU or one
// memory port access; a divide waits for the divider, and interrupt entry adds two pushes
// and the handler jump.
// Throughput: one instruction at a time; the next is taken after its result beat is taken.
// Reset: registers, control registers and flags clear at once; then a clearing pass
// zeroes the data memory, and req_ready_o stays low until it ends.
module toy_cpu_execute_unit_top import tce_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  typedef enum logic [23:0] {
    S_CLR     = 24'h000001,
    S_IDLE    = 24'h000002,
    S_PC      = 24'h000004,
    S_DISP    = 24'h000008,
    S_RA      = 24'h000010,
    S_RB      = 24'h000020,
    S_RC      = 24'h000040,
    S_EXEC    = 24'h000080,
    S_AD2     = 24'h000100,
    S_MRD     = 24'h000200,
    S_MRDW    = 24'h000400,
    S_MWR     = 24'h000800,
    S_CMP     = 24'h001000,
    S_SWP2    = 24'h002000,
    S_DIVW    = 24'h004000,
    S_LPOST   = 24'h008000,
    S_PUSHD   = 24'h010000,
    S_PUSHW   = 24'h020000,
    S_TRAPFIN = 24'h040000,
    S_KEY     = 24'h080000,
    S_INTFIN  = 24'h100000,
    S_BAD     = 24'h200000,
    S_FIN     = 24'h400000,
    S_OUT     = 24'h800000
  } state_e;

  state_e state_q, state_d, ret_q;

  logic [31:0] gpr_q [16];
  logic [31:0] mem_q [MEM_WORDS];
  logic [31:0] status_q, handler_q, cause_q;
  logic [7:0]  term_q;
  logic        stopped_q, bad_q, intr_q, push2_q;
  logic [MEM_AW-1:0] clr_q;

  req_t        req_q;
  res_t        res_q;
  logic [31:0] opa_q, opb_q, opc_q, addr_q, wd_q, rd_q, pv0_q, pv1_q, mrd_q;
  logic        term_hit_q;

  // decoded fields
  logic [3:0]  code, mode, ia, ib, ic;
  logic [31:0] dext;
  assign code = req_q.req_type;
  assign mode = req_q.op_mode;
  assign ia   = req_q.reg_a;
  assign ib   = req_q.reg_b;
  assign ic   = req_q.reg_c;
  assign dext = {{(32-DISP_BITS){req_q.displacement[DISP_BITS-1]}}, req_q.displacement};

  // control signals
  alu_op_e     alu_op;
  logic [31:0] alu_x, alu_y, alu_r;
  logic        alu_cond;
  logic [3:0]  rf_ra, rf_wa;
  logic [31:0] rf_rd, rf_wd;
  logic        rf_we, mem_we, csr_we, bad_c, take_int;
  logic [31:0] csr_wd, csr_b, csr_c, mrd;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  tce_alu u_alu (
    .op_i   (alu_op),
    .x_i    (alu_x),
    .y_i    (alu_y),
    .r_o    (alu_r),
    .cond_o (alu_cond)
  );

  tce_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign rf_rd    = gpr_q[rf_ra];
  assign mrd      = term_hit_q ? {24'd0, term_q} : mrd_q;
  assign take_int = req_q.key_valid && (status_q[1:0] == 2'b00);

  // control register reads at the b and c fields
  always_comb begin
    case (ib)
      CSR_STATUS:  csr_b = status_q;
      CSR_HANDLER: csr_b = handler_q;
      CSR_CAUSE:   csr_b = cause_q;
      default:     csr_b = '0;
    endcase
    case (ic)
      CSR_STATUS:  csr_c = status_q;
      CSR_HANDLER: csr_c = handler_q;
      CSR_CAUSE:   csr_c = cause_q;
      default:     csr_c = '0;
    endcase
  end

  // unknown code or mode
  always_comb begin
    case (code)
      OP_HALT, OP_TRAP, OP_SWAP: bad_c = 1'b0;
      OP_CALL:           bad_c = !(mode inside {CALL_DIR, CALL_IND});
      OP_JUMP:           bad_c = mode[2];
      OP_ARITH, OP_LOGIC: bad_c = |mode[3:2];
      OP_SHIFT:          bad_c = |mode[3:1];
      OP_STORE:          bad_c = !(mode inside {ST_DIR, ST_CSR, ST_IND});
      OP_LOAD:           bad_c = mode[3];
      default:           bad_c = 1'b1;
    endcase
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    alu_op   = ALU_ADD;
    alu_x    = '0;
    alu_y    = '0;
    rf_ra    = REG_PC;
    rf_we    = 1'b0;
    rf_wa    = ia;
    rf_wd    = alu_r;
    mem_we   = 1'b0;
    csr_we   = 1'b0;
    csr_wd   = alu_r;
    div_req.start    = 1'b0;
    div_req.dividend = opb_q;
    div_req.divisor  = opc_q;
    case (state_q)
      S_CLR: begin
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) state_d = S_PC;
      end
      S_PC: begin
        alu_x = rf_rd;
        alu_y = 32'd4;
        if (stopped_q) begin
          state_d = S_FIN;
        end else begin
          rf_we   = 1'b1;
          rf_wa   = REG_PC;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (bad_c)                                 state_d = S_BAD;
        else if (code == OP_TRAP || code == OP_CALL) state_d = S_PUSHD;
        else if (code == OP_HALT)                  state_d = S_KEY;
        else                                       state_d = S_RA;
      end
      S_RA: begin
        rf_ra   = ia;
        state_d = S_RB;
      end
      S_RB: begin
        rf_ra   = ib;
        state_d = S_RC;
      end
      S_RC: begin
        rf_ra   = ic;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_KEY;
        case (code)
          OP_CALL: begin
            alu_x = opa_q; alu_y = opb_q; state_d = S_AD2;
          end
          OP_JUMP: begin
            alu_x = opa_q; state_d = S_AD2;
          end
          OP_SWAP: begin
            rf_we = 1'b1; rf_wd = opb_q; state_d = S_SWP2;
          end
          OP_ARITH: begin
            alu_x = opb_q; alu_y = opc_q;
            case (mode)
              M_ADD:   alu_op = ALU_ADD;
              M_SUB:   alu_op = ALU_SUB;
              M_MUL:   alu_op = ALU_MUL;
              default: alu_op = ALU_ADD;
            endcase
            if (mode == M_DIV) begin
              div_req.start = 1'b1;
              state_d       = S_DIVW;
            end else begin
              rf_we = 1'b1;
            end
          end
          OP_LOGIC: begin
            alu_x = opb_q; alu_y = opc_q; rf_we = 1'b1;
            case (mode)
              M_NOT:   alu_op = ALU_NOT;
              M_AND:   alu_op = ALU_AND;
              M_OR:    alu_op = ALU_OR;
              M_XOR:   alu_op = ALU_XOR;
              default: alu_op = ALU_NOT;
            endcase
          end
          OP_SHIFT: begin
            alu_x = opb_q; alu_y = opc_q; rf_we = 1'b1;
            alu_op = (mode == M_SHL) ? ALU_SHL : ALU_SHR;
          end
          OP_STORE: begin
            alu_x   = opa_q;
            alu_y   = (mode == ST_CSR) ? '0 : opb_q;
            state_d = S_AD2;
          end
          OP_LOAD: begin
            case (mode)
              LD_CSR: begin
                rf_we = 1'b1; rf_wd = csr_b;
              end
              LD_ADDI: begin
                alu_x = opb_q; state_d = S_AD2;
              end
              LD_MEM, LD_MCSR: begin
                alu_x = opb_q; alu_y = opc_q; state_d = S_AD2;
              end
              LD_POST, LD_MPOST: begin
                alu_x = opb_q; state_d = S_MRD;
              end
              LD_WCSR: begin
                csr_we = 1'b1; csr_wd = opb_q;
              end
              LD_ORCSR: begin
                alu_op = ALU_OR; alu_x = csr_b; alu_y = dext; csr_we = 1'b1;
              end
              default: state_d = S_KEY;
            endcase
          end
          default: state_d = S_KEY;
        endcase
      end
      S_AD2: begin
        // second half of the address sum: add the displacement, except for a control register store through r0
        alu_x = addr_q;
        alu_y = (code == OP_STORE && mode == ST_CSR && ia == REG_ZERO) ? '0 : dext;
        state_d = S_MRD;
        case (code)
          OP_CALL: begin
            if (mode == CALL_DIR) begin
              rf_we = 1'b1; rf_wa = REG_PC; state_d = S_KEY;
            end
          end
          OP_JUMP: begin
            if (!mode[JMP_IND_BIT]) state_d = S_CMP;
          end
          OP_STORE: begin
            if (mode == ST_DIR) begin
              state_d = S_MWR;
            end else if (mode == ST_CSR) begin
              rf_we = 1'b1; state_d = S_MWR;
            end
          end
          OP_LOAD: begin
            if (mode == LD_ADDI) begin
              rf_we = 1'b1; state_d = S_KEY;
            end
          end
          default: state_d = S_KEY;
        endcase
      end
      S_MRD: begin
        state_d = S_MRDW;
      end
      S_MRDW: begin
        state_d = S_KEY;
        rf_wd   = mrd;
        csr_wd  = mrd;
        case (code)
          OP_CALL:  begin rf_we = 1'b1; rf_wa = REG_PC; end
          OP_JUMP:  state_d = S_CMP;
          OP_STORE: state_d = S_MWR;
          OP_LOAD: begin
            case (mode)
              LD_MEM:   rf_we = 1'b1;
              LD_POST:  begin rf_we = 1'b1; state_d = S_LPOST; end
              LD_MCSR:  csr_we = 1'b1;
              LD_MPOST: begin csr_we = 1'b1; state_d = S_LPOST; end
              default:  state_d = S_KEY;
            endcase
          end
          default: state_d = S_KEY;
        endcase
      end
      S_MWR: begin
        mem_we  = 1'b1;
        state_d = S_KEY;
      end
      S_CMP: begin
        alu_x = opb_q;
        alu_y = opc_q;
        rf_wa = REG_PC;
        rf_wd = addr_q;
        case (mode[2:0])
          BR_EQ:   alu_op = ALU_EQ;
          BR_NE:   alu_op = ALU_NE;
          BR_GT:   alu_op = ALU_GT;
          default: alu_op = ALU_EQ;
        endcase
        rf_we   = (mode[2:0] == BR_ALW) || alu_cond;
        state_d = S_KEY;
      end
      S_SWP2: begin
        rf_we = 1'b1; rf_wa = ib; rf_wd = opa_q; state_d = S_KEY;
      end
      S_DIVW: begin
        rf_wd = div_rsp.quotient;
        if (div_rsp.done) begin
          rf_we = 1'b1; state_d = S_KEY;
        end
      end
      S_LPOST: begin
        // post-increment; load into the same register adds to the loaded word
        alu_x = (mode == LD_POST && ia == ib) ? rd_q : opb_q;
        alu_y = dext;
        rf_we = 1'b1; rf_wa = ib; state_d = S_KEY;
      end
      S_PUSHD: begin
        rf_ra  = REG_SP;
        alu_op = ALU_SUB;
        alu_x  = rf_rd;
        alu_y  = 32'd4;
        rf_we  = 1'b1; rf_wa = REG_SP; state_d = S_PUSHW;
      end
      S_PUSHW: begin
        mem_we  = 1'b1;
        state_d = push2_q ? S_PUSHD : ret_q;
      end
      S_TRAPFIN: begin
        rf_we = 1'b1; rf_wa = REG_PC; rf_wd = handler_q; state_d = S_KEY;
      end
      S_KEY: begin
        state_d = take_int ? S_PUSHD : S_FIN;
      end
      S_INTFIN: begin
        rf_we = 1'b1; rf_wa = REG_PC; rf_wd = handler_q; state_d = S_FIN;
      end
      S_BAD: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control, architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      ret_q     <= S_IDLE;
      clr_q     <= '0;
      stopped_q <= 1'b0;
      bad_q     <= 1'b0;
      intr_q    <= 1'b0;
      push2_q   <= 1'b0;
      status_q  <= '0;
      handler_q <= '0;
      cause_q   <= '0;
      term_q    <= '0;
      for (int i = 0; i < 16; i++) gpr_q[i] <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_CLR:  clr_q <= clr_q + 1'b1;
        S_IDLE: begin
          if (req_valid_i) begin
            bad_q  <= 1'b0;
            intr_q <= 1'b0;
          end
        end
        S_DISP: begin
          if (!bad_c) begin
            if (code == OP_HALT) stopped_q <= 1'b1;
            if (code == OP_TRAP) begin
              push2_q <= 1'b1;
              ret_q   <= S_TRAPFIN;
            end
            if (code == OP_CALL) begin
              push2_q <= 1'b0;
              ret_q   <= S_RA;
            end
          end
        end
        S_PUSHW:   if (push2_q) push2_q <= 1'b0;
        S_TRAPFIN: begin
          status_q[0] <= 1'b0;
          cause_q     <= CAUSE_TRAP;
        end
        S_KEY: begin
          if (take_int) begin
            push2_q <= 1'b1;
            ret_q   <= S_INTFIN;
            intr_q  <= 1'b1;
          end
        end
        S_INTFIN: begin
          status_q[0] <= 1'b0;
          cause_q     <= CAUSE_KEY;
          term_q      <= req_q.key_char;
        end
        S_BAD: begin
          bad_q     <= 1'b1;
          stopped_q <= 1'b1;
        end
        default: ;
      endcase
      // register file write; r0 stays zero
      if (rf_we && rf_wa != REG_ZERO) gpr_q[rf_wa] <= rf_wd;
      // control register write
      if (csr_we) begin
        case (ia)
          CSR_STATUS:  status_q  <= csr_wd;
          CSR_HANDLER: handler_q <= csr_wd;
          CSR_CAUSE:   cause_q   <= csr_wd;
          default: ;
        endcase
      end
      // terminal cell
      if (mem_we && addr_q == TERM_ADDR) term_q <= wd_q[7:0];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (req_valid_i) req_q <= req_i;
      S_DISP: begin
        if (code == OP_TRAP) begin
          pv0_q <= status_q;
          pv1_q <= rf_rd;
        end else begin
          pv0_q <= rf_rd;
        end
      end
      S_RA:   opa_q <= rf_rd;
      S_RB:   opb_q <= rf_rd;
      S_RC:   opc_q <= rf_rd;
      S_EXEC: addr_q <= alu_r;
      S_AD2: begin
        addr_q <= alu_r;
        wd_q   <= (code == OP_STORE && mode == ST_CSR) ? csr_c : opc_q;
      end
      S_MRDW: begin
        rd_q   <= mrd;
        addr_q <= mrd;
      end
      S_PUSHD: begin
        addr_q <= alu_r;
        wd_q   <= pv0_q;
      end
      S_PUSHW: if (push2_q) pv0_q <= pv1_q;
      S_KEY: begin
        pv0_q <= rf_rd;
        pv1_q <= status_q;
      end
      S_FIN: begin
        res_q.next_pc         <= rf_rd;
        res_q.halted          <= stopped_q;
        res_q.invalid_op      <= bad_q;
        res_q.interrupt_taken <= intr_q;
      end
      default: ;
    endcase
  end

  // data memory: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLR) begin
      mem_q[clr_q] <= '0;
    end else if (mem_we && addr_q != TERM_ADDR) begin
      mem_q[addr_q[MEM_AW+1:2]] <= wd_q;
    end
    mrd_q      <= mem_q[addr_q[MEM_AW+1:2]];
    term_hit_q <= (addr_q == TERM_ADDR);
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

endmodule

/* hdl/tce_checker.sv */
// Port-level assertions for the execute unit, bound to the top level.
module tce_checker import tce_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_o,
  input logic res_valid_o,
  input logic res_ready_i,
  input res_t res_o
);

  // one instruction in flight: never ready while a result beat waits
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready_o && res_valid_o))
    else $error("ready while result pending");

  // an accepted beat closes the input side
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> !req_ready_o)
    else $error("ready right after accept");

  // an invalid instruction stops the machine and skips the interrupt
  a_invalid_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.invalid_op) |-> (res_o.halted && !res_o.interrupt_taken))
    else $error("invalid without halt or with interrupt");

  // a stalled result beat holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(res_o)))
    else $error("result beat changed while stalled");

  // exactly one result beat per instruction
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_ready_i) |=> !res_valid_o)
    else $error("second result beat");

endmodule

bind toy_cpu_execute_unit_top tce_checker u_tce_checker (.*);

/* dv/toy_cpu_execute_unit_top_tb.sv */
// Testbench for the toy CPU execute unit: directed table, random programs, scoreboard.
`timescale 1ns / 100ps

module toy_cpu_execute_unit_top_tb;
  import tce_pkg::*;

  localparam int unsigned N_RANDOM   = 1750;
  localparam int unsigned CYCLE_CAP  = 1000000;
  localparam int unsigned DRAIN_WAIT = 80;

  typedef struct {
    req_t r;
    bit   typed;
    res_t e;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic req_valid_i;
  logic req_ready_o;
  req_t req_i;
  logic res_valid_o;
  logic res_ready_i;
  res_t res_o;

  toy_cpu_execute_unit_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req_valid_i), .req_ready_o(req_ready_o), .req_i(req_i),
    .res_valid_o(res_valid_o), .res_ready_i(res_ready_i), .res_o(res_o)
  );

  // Machine state mirrored by the predictor
  logic [31:0] gpr [16];
  logic [31:0] csr_status, csr_handler, csr_cause;
  logic [31:0] dmem [MEM_WORDS];
  logic [7:0]  term_in;
  bit          machine_stopped;

  res_t        pending_res [$];
  stim_row_t   dir_tab [$];
  int unsigned errs, cyc, n_beats, n_irq, n_traps;
  bit          no_idle;

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Word memory with the terminal cell mapped in
  function automatic logic [31:0] mem_read(logic [31:0] a);
    if (a == TERM_ADDR) return {24'd0, term_in};
    return dmem[(a >> 2) % MEM_WORDS];
  endfunction

  function automatic void mem_write(logic [31:0] a, logic [31:0] v);
    if (a == TERM_ADDR) term_in = v[7:0];
    else dmem[(a >> 2) % MEM_WORDS] = v;
  endfunction

  function automatic logic [31:0] csr_read(logic [3:0] i);
    case (i)
      CSR_STATUS:  return csr_status;
      CSR_HANDLER: return csr_handler;
      CSR_CAUSE:   return csr_cause;
      default:     return 32'd0;
    endcase
  endfunction

  function automatic void csr_write(logic [3:0] i, logic [31:0] v);
    case (i)
      CSR_STATUS:  csr_status = v;
      CSR_HANDLER: csr_handler = v;
      CSR_CAUSE:   csr_cause = v;
      default: ;
    endcase
  endfunction

  function automatic void stack_push(logic [31:0] v);
    gpr[REG_SP] = gpr[REG_SP] - 32'd4;
    mem_write(gpr[REG_SP], v);
  endfunction

  // Executes one instruction on the mirrored state, returns the result beat
  function automatic res_t exec_instr(req_t r);
    res_t        o;
    logic [31:0] d, addr, t;
    logic [3:0]  a, b, c, m;
    bit          bad, irq, take;
    a = r.reg_a; b = r.reg_b; c = r.reg_c; m = r.op_mode;
    d = {{(32-DISP_BITS){r.displacement[DISP_BITS-1]}}, r.displacement};
    bad = 1'b0; irq = 1'b0;
    if (machine_stopped) begin
      o.next_pc = gpr[REG_PC]; o.halted = 1'b1; o.invalid_op = 1'b0;
      o.interrupt_taken = 1'b0;
      return o;
    end
    gpr[REG_PC] = gpr[REG_PC] + 32'd4;
    case (r.req_type)
      OP_HALT: machine_stopped = 1'b1;
      OP_TRAP: begin
        stack_push(csr_status);
        stack_push(gpr[REG_PC]);
        csr_cause = CAUSE_TRAP;
        csr_status[0] = 1'b0;
        gpr[REG_PC] = csr_handler;
      end
      OP_CALL: begin
        if (m > CALL_IND) bad = 1'b1;
        else begin
          stack_push(gpr[REG_PC]);
          addr = gpr[a] + gpr[b] + d;
          gpr[REG_PC] = (m == CALL_DIR) ? addr : mem_read(addr);
        end
      end
      OP_JUMP: begin
        if (m[2:0] > BR_GT) bad = 1'b1;
        else begin
          addr = gpr[a] + d;
          if (m[JMP_IND_BIT]) addr = mem_read(addr);
          case (m[2:0])
            BR_ALW:  take = 1'b1;
            BR_EQ:   take = (gpr[b] == gpr[c]);
            BR_NE:   take = (gpr[b] != gpr[c]);
            default: take = ($signed(gpr[b]) > $signed(gpr[c]));
          endcase
          if (take) gpr[REG_PC] = addr;
        end
      end
      OP_SWAP: begin
        t = gpr[a]; gpr[a] = gpr[b]; gpr[b] = t;
      end
      OP_ARITH, OP_LOGIC: begin
        t = 32'd0;
        if (m > 4'd3) bad = 1'b1;
        else if (r.req_type == OP_ARITH) begin
          case (m)
            M_ADD:   t = gpr[b] + gpr[c];
            M_SUB:   t = gpr[b] - gpr[c];
            M_MUL:   t = gpr[b] * gpr[c];
            default: t = (gpr[c] != 0) ? gpr[b] / gpr[c] : 32'hFFFF_FFFF;
          endcase
        end else begin
          case (m)
            M_NOT:   t = ~gpr[b];
            M_AND:   t = gpr[b] & gpr[c];
            M_OR:    t = gpr[b] | gpr[c];
            default: t = gpr[b] ^ gpr[c];
          endcase
        end
        if (!bad && a != REG_ZERO) gpr[a] = t;
      end
      OP_SHIFT: begin
        if (m > M_SHR) bad = 1'b1;
        else begin
          if (gpr[c] >= 32) t = 32'd0;
          else t = (m == M_SHL) ? (gpr[b] << gpr[c][4:0]) : (gpr[b] >> gpr[c][4:0]);
          if (a != REG_ZERO) gpr[a] = t;
        end
      end
      OP_STORE: begin
        case (m)
          ST_DIR: mem_write(gpr[a] + gpr[b] + d, gpr[c]);
          ST_IND: begin
            addr = mem_read(gpr[a] + gpr[b] + d);
            mem_write(addr, gpr[c]);
          end
          ST_CSR: begin
            if (a != REG_ZERO) gpr[a] = gpr[a] + d;
            mem_write(gpr[a], csr_read(c));
          end
          default: bad = 1'b1;
        endcase
      end
      OP_LOAD: begin
        case (m)
          LD_CSR:  if (a != REG_ZERO) gpr[a] = csr_read(b);
          LD_ADDI: if (a != REG_ZERO) gpr[a] = gpr[b] + d;
          LD_MEM: begin
            t = mem_read(gpr[b] + gpr[c] + d);
            if (a != REG_ZERO) gpr[a] = t;
          end
          LD_POST: begin
            t = mem_read(gpr[b]);
            if (a != REG_ZERO) gpr[a] = t;
            if (b != REG_ZERO) gpr[b] = gpr[b] + d;
          end
          LD_WCSR:  csr_write(a, gpr[b]);
          LD_ORCSR: csr_write(a, csr_read(b) | d);
          LD_MCSR:  csr_write(a, mem_read(gpr[b] + gpr[c] + d));
          LD_MPOST: begin
            csr_write(a, mem_read(gpr[b]));
            if (b != REG_ZERO) gpr[b] = gpr[b] + d;
          end
          default: bad = 1'b1;
        endcase
      end
      default: bad = 1'b1;
    endcase
    gpr[REG_ZERO] = 32'd0;
    // Terminal key entry, skipped after an invalid instruction
    if (bad) machine_stopped = 1'b1;
    else if (r.key_valid && csr_status[1:0] == 2'b00) begin
      irq = 1'b1;
      stack_push(gpr[REG_PC]);
      stack_push(csr_status);
      csr_status[0] = 1'b0;
      csr_cause = CAUSE_KEY;
      gpr[REG_PC] = csr_handler;
      mem_write(TERM_ADDR, {24'd0, r.key_char});
      gpr[REG_ZERO] = 32'd0;
    end
    o.next_pc = gpr[REG_PC]; o.halted = machine_stopped; o.invalid_op = bad;
    o.interrupt_taken = irq;
    return o;
  endfunction

  function automatic req_t instr(logic [3:0] code, logic [3:0] m, logic [3:0] a,
                                 logic [3:0] b, logic [3:0] c, int d);
    req_t r;
    r = '0;
    r.req_type = code; r.op_mode = m; r.reg_a = a; r.reg_b = b; r.reg_c = c;
    r.displacement = d[DISP_BITS-1:0];
    return r;
  endfunction

  // Random instruction with a legal code and mode
  function automatic req_t rand_instr();
    req_t        r;
    logic [3:0]  code;
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 3) code = OP_TRAP;
    else if (w < 8) code = OP_CALL;
    else if (w < 18) code = OP_JUMP;
    else if (w < 23) code = OP_SWAP;
    else if (w < 38) code = OP_ARITH;
    else if (w < 48) code = OP_LOGIC;
    else if (w < 56) code = OP_SHIFT;
    else if (w < 70) code = OP_STORE;
    else code = OP_LOAD;
    r = req_t'({$urandom, $urandom});
    r.req_type = code;
    case (code)
      OP_CALL:  r.op_mode = $urandom_range(0, 1);
      OP_JUMP:  r.op_mode = {r.op_mode[3], 1'b0, r.op_mode[1:0]};
      OP_ARITH, OP_LOGIC: r.op_mode = $urandom_range(0, 3);
      OP_SHIFT: r.op_mode = $urandom_range(0, 1);
      OP_STORE: r.op_mode = $urandom_range(0, 2);
      OP_LOAD:  r.op_mode = $urandom_range(0, 7);
      default: ;
    endcase
    r.key_valid = ($urandom_range(0, 9) == 0);
    return r;
  endfunction

  // Sender; entered and left at a falling edge
  task automatic send_instr(req_t r, bit typed, res_t e);
    res_t p;
    while (!no_idle && $urandom_range(0, 99) < 7) begin
      req_valid_i = 1'b0;
      @(negedge clk_i);
    end
    req_valid_i = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (!req_ready_o);
    p = exec_instr(r);
    pending_res.push_back(typed ? e : p);
    if (p.interrupt_taken) n_irq++;
    if (r.req_type == OP_TRAP && !p.halted) n_traps++;
    @(negedge clk_i);
  endtask

  // Receiver stall
  always @(negedge clk_i) begin
    res_ready_i <= no_idle || ($urandom_range(0, 99) >= 7);
  end

  // Result checker
  always @(posedge clk_i) begin
    res_t x;
    if (rst_ni && res_valid_o && res_ready_i) begin
      n_beats++;
      if (pending_res.size() == 0) begin
        $error("result beat with nothing expected: %h", res_o);
        errs++;
      end else begin
        x = pending_res.pop_front();
        if (res_o.next_pc !== x.next_pc) begin
          $error("next_pc exp %h got %h", x.next_pc, res_o.next_pc); errs++;
        end
        if (res_o.halted !== x.halted) begin
          $error("halted exp %b got %b", x.halted, res_o.halted); errs++;
        end
        if (res_o.invalid_op !== x.invalid_op) begin
          $error("invalid_op exp %b got %b", x.invalid_op, res_o.invalid_op); errs++;
        end
        if (res_o.interrupt_taken !== x.interrupt_taken) begin
          $error("interrupt_taken exp %b got %b", x.interrupt_taken,
                 res_o.interrupt_taken);
          errs++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CYCLE_CAP) begin
      $display("FAIL toy_cpu_execute_unit_top");
      $finish;
    end
  end

  task automatic add_row(req_t r, bit typed, res_t e);
    stim_row_t s;
    s.r = r; s.typed = typed; s.e = e;
    dir_tab.push_back(s);
  endtask

  initial begin
    req_t r;
    res_t none;
    int   k;
    req_valid_i = 1'b0; req_i = '0; res_ready_i = 1'b0;
    errs = 0; cyc = 0; n_beats = 0; n_irq = 0; n_traps = 0; no_idle = 1'b0;
    none = '0;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    csr_status = '0; csr_handler = '0; csr_cause = '0; term_in = '0;
    machine_stopped = 1'b0;

    // Directed table
    add_row(instr(OP_ARITH, M_ADD, 1, 0, 0, 0), 1'b1, '{32'd4, 1'b0, 1'b0, 1'b0});
    add_row(instr(OP_LOAD, LD_ADDI, 1, 0, 0, -252), 1'b1, '{32'd8, 1'b0, 1'b0, 1'b0});
    add_row(instr(OP_LOAD, LD_ADDI, 2, 0, 0, 2047), 1'b0, none);
    add_row(instr(OP_LOAD, LD_ADDI, 3, 0, 0, -2048), 1'b0, none);
    add_row(instr(OP_STORE, ST_DIR, 1, 0, 3, 0), 1'b0, none);   // terminal cell write
    add_row(instr(OP_LOAD, LD_MEM, 4, 0, 1, 0), 1'b0, none);    // terminal cell read
    add_row(instr(OP_STORE, ST_DIR, 2, 0, 3, 3), 1'b0, none);   // unaligned
    add_row(instr(OP_SHIFT, M_SHL, 5, 2, 3, 0), 1'b0, none);    // shift of 32 or more
    add_row(instr(OP_ARITH, M_DIV, 6, 2, 0, 0), 1'b0, none);    // divide by zero
    add_row(instr(OP_ARITH, M_SUB, 7, 0, 2, 0), 1'b0, none);
    add_row(instr(OP_ARITH, M_MUL, 8, 3, 3, 0), 1'b0, none);
    add_row(instr(OP_ARITH, M_DIV, 9, 3, 2, 0), 1'b0, none);
    add_row(instr(OP_LOGIC, M_NOT, 10, 0, 0, 0), 1'b0, none);
    add_row(instr(OP_LOGIC, M_AND, 11, 10, 3, 0), 1'b0, none);
    add_row(instr(OP_LOGIC, M_OR, 12, 2, 3, 0), 1'b0, none);
    add_row(instr(OP_LOGIC, M_XOR, 0, 2, 3, 0), 1'b0, none);    // r0 stays zero
    add_row(instr(OP_SHIFT, M_SHR, 13, 10, 4, 0), 1'b0, none);
    add_row(instr(OP_SWAP, 0, 4, 2, 0, 0), 1'b0, none);
    add_row(instr(OP_LOAD, LD_WCSR, CSR_HANDLER, 12, 0, 0), 1'b0, none);
    add_row(instr(OP_LOAD, LD_ORCSR, 3, 2, 0, -1), 1'b0, none); // high index ignored
    add_row(instr(OP_LOAD, LD_CSR, 5, 7, 0, 0), 1'b0, none);
    add_row(instr(OP_STORE, ST_CSR, REG_SP, 0, CSR_HANDLER, -8), 1'b0, none);
    add_row(instr(OP_STORE, ST_IND, 4, 0, 10, 8), 1'b0, none);
    add_row(instr(OP_LOAD, LD_POST, 5, REG_SP, 0, 4), 1'b0, none);
    add_row(instr(OP_LOAD, LD_MCSR, CSR_CAUSE, REG_SP, 0, -4), 1'b0, none);
    add_row(instr(OP_LOAD, LD_MPOST, CSR_STATUS, 1, 0, 4), 1'b0, none);
    add_row(instr(OP_CALL, CALL_DIR, 2, 3, 0, 12), 1'b0, none);
    add_row(instr(OP_CALL, CALL_IND, REG_SP, 0, 0, 0), 1'b0, none);
    add_row(instr(OP_JUMP, {1'b0, BR_EQ}, 2, 6, 10, 16), 1'b0, none);
    add_row(instr(OP_JUMP, {1'b0, BR_NE}, 2, 6, 10, 16), 1'b0, none);
    add_row(instr(OP_JUMP, {1'b0, BR_GT}, 2, 0, 3, -16), 1'b0, none);
    add_row(instr(OP_JUMP, {1'b1, BR_ALW}, REG_SP, 0, 0, 0), 1'b0, none);
    add_row(instr(OP_TRAP, 0, 0, 0, 0, 0), 1'b0, none);
    r = instr(OP_LOAD, LD_WCSR, CSR_STATUS, 0, 0, 0);
    add_row(r, 1'b0, none);
    r = instr(OP_ARITH, M_ADD, 1, 1, 1, 0);
    r.key_valid = 1'b1; r.key_char = 8'hFF;                     // key interrupt entry
    add_row(r, 1'b0, none);

    @(posedge rst_ni);
    @(negedge clk_i);
    foreach (dir_tab[i]) send_instr(dir_tab[i].r, dir_tab[i].typed, dir_tab[i].e);

    // Random programs; a quiet stretch and one full drain in the middle
    for (k = 0; k < N_RANDOM; k++) begin
      no_idle = (k >= 600 && k < 900);
      if (k == 1000) begin
        req_valid_i = 1'b0;
        while (pending_res.size() != 0) @(negedge clk_i);
      end
      send_instr(rand_instr(), 1'b0, none);
    end
    no_idle = 1'b0;

    // Stop the machine by halt or by a bad encoding, then items that are ignored
    r = rand_instr();
    case ($urandom_range(0, 2))
      0: r.req_type = OP_HALT;
      1: r.req_type = $urandom_range(10, 15);
      default: begin
        r.req_type = OP_ARITH;
        r.op_mode = $urandom_range(4, 15);
      end
    endcase
    send_instr(r, 1'b0, none);
    repeat (4) send_instr(rand_instr(), 1'b0, none);
    req_valid_i = 1'b0;

    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    $display("Covered %0d result beats: all codes and modes, %0d key interrupts, %0d traps,",
             n_beats, n_irq, n_traps);
    $display("ending with a stopped machine that ignores further instructions.");
    if (errs == 0) begin
      $display("PASS toy_cpu_execute_unit_top");
    end else begin
      $display("FAIL toy_cpu_execute_unit_top");
    end
    $finish;
  end

endmodule
